>>> hw/rtl/dips_pkg.sv
// Shared types and codes for the dual-issue port scoreboard.
// No dependencies; used by every module under hw/rtl.
package dips_pkg;

    localparam int TIME_BITS_DEF    = 32;
    localparam int LATENCY_BITS_DEF = 8;

    // Input beat
    typedef struct packed {
        logic        action;
        logic [31:0] cycle_now;
        logic [1:0]  slot_class;
        logic [3:0]  port_class;
        logic [7:0]  unit_latency;
    } dips_in_t;

    // Result beat
    typedef struct packed {
        logic       issued;
        logic [2:0] unit_chosen;
    } dips_out_t;

    // Execution unit codes
    typedef enum logic [2:0] {
        UNIT_NONE = 3'd0,
        UNIT_MUL  = 3'd1,
        UNIT_DIV  = 3'd2,
        UNIT_SIM0 = 3'd3,
        UNIT_SIM1 = 3'd4
    } unit_t;

    // Actions
    localparam logic ACT_NEW_CYCLE = 1'b0;
    localparam logic ACT_ISSUE     = 1'b1;

    // Slot classes
    localparam logic [1:0] SC_BOTH = 2'd0;
    localparam logic [1:0] SC_S0   = 2'd1;
    localparam logic [1:0] SC_S1   = 2'd2;
    localparam logic [1:0] SC_ANY  = 2'd3;

    // Port classes (anything above PC_NONE behaves as none)
    localparam logic [3:0] PC_BR       = 4'd0;
    localparam logic [3:0] PC_BR_INT   = 4'd1;
    localparam logic [3:0] PC_INT_ANY  = 4'd2;
    localparam logic [3:0] PC_SIM0     = 4'd3;
    localparam logic [3:0] PC_SIM1     = 4'd4;
    localparam logic [3:0] PC_SIM_ANY  = 4'd5;
    localparam logic [3:0] PC_LDST     = 4'd6;
    localparam logic [3:0] PC_INT0     = 4'd7;
    localparam logic [3:0] PC_INT1     = 4'd8;
    localparam logic [3:0] PC_LDST_INT = 4'd9;
    localparam logic [3:0] PC_NONE     = 4'd10;

    // Port flag bit positions
    localparam int PF_BR   = 0;
    localparam int PF_INT0 = 1;
    localparam int PF_INT1 = 2;
    localparam int PF_SIM0 = 3;
    localparam int PF_SIM1 = 4;
    localparam int PF_LDST = 5;

endpackage

>>> hw/rtl/dips_sched.sv
// Slot/port claim logic and unit busy-until state of the scoreboard.
// Depends on dips_pkg. Evaluates one beat per cycle while step is high and updates state at once.
module dips_sched #(
    parameter int TIME_BITS    = dips_pkg::TIME_BITS_DEF,
    parameter int LATENCY_BITS = dips_pkg::LATENCY_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  dips_pkg::dips_in_t  in_data,
    output dips_pkg::dips_out_t res_data
);

    localparam int LAT_EFF = (LATENCY_BITS < 8) ? LATENCY_BITS : 8;
    localparam logic [7:0] LAT_MASK = 8'((9'(1) << LAT_EFF) - 9'(1));
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    logic [1:0]           slot_reg;
    logic [5:0]           port_reg;
    logic [TIME_BITS-1:0] cur_reg;
    logic [TIME_BITS-1:0] busy_reg [4];

    logic                 slot_ok;
    logic [1:0]           slot_new;
    logic                 port_ok;
    logic [5:0]           port_new;
    dips_pkg::unit_t      unit;
    logic                 ints_full;
    logic                 simd_full;
    dips_pkg::unit_t      int_unit;
    logic [5:0]           int_bits;
    dips_pkg::unit_t      sim_unit;
    logic [5:0]           sim_bits;
    logic [1:0]           uidx;
    logic                 unit_busy;
    logic [7:0]           lat;
    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS-1:0] busy_new;

    // Slot claim
    always_comb begin
        slot_ok  = 1'b1;
        slot_new = slot_reg;
        unique case (in_data.slot_class)
            dips_pkg::SC_BOTH: begin
                slot_ok  = (slot_reg == 2'b00);
                slot_new = 2'b11;
            end
            dips_pkg::SC_S0: begin
                slot_ok  = !slot_reg[0];
                slot_new = slot_reg | 2'b01;
            end
            dips_pkg::SC_S1: begin
                slot_ok  = !slot_reg[1];
                slot_new = slot_reg | 2'b10;
            end
            default: begin
                slot_ok  = (slot_reg != 2'b11);
                slot_new = slot_reg | (slot_reg[0] ? 2'b10 : 2'b01);
            end
        endcase
    end

    // Preferred integer / simd port within a pair
    always_comb begin
        ints_full = port_reg[dips_pkg::PF_INT0] && port_reg[dips_pkg::PF_INT1];
        simd_full = port_reg[dips_pkg::PF_SIM0] && port_reg[dips_pkg::PF_SIM1];
        int_bits  = '0;
        sim_bits  = '0;
        if (port_reg[dips_pkg::PF_INT0]) begin
            int_unit = dips_pkg::UNIT_DIV;
            int_bits[dips_pkg::PF_INT1] = 1'b1;
        end else begin
            int_unit = dips_pkg::UNIT_MUL;
            int_bits[dips_pkg::PF_INT0] = 1'b1;
        end
        if (port_reg[dips_pkg::PF_SIM0]) begin
            sim_unit = dips_pkg::UNIT_SIM1;
            sim_bits[dips_pkg::PF_SIM1] = 1'b1;
        end else begin
            sim_unit = dips_pkg::UNIT_SIM0;
            sim_bits[dips_pkg::PF_SIM0] = 1'b1;
        end
    end

    // Port claim by class
    always_comb begin
        port_ok  = 1'b1;
        port_new = port_reg;
        unit     = dips_pkg::UNIT_NONE;
        unique case (in_data.port_class)
            dips_pkg::PC_BR: begin
                port_ok = !port_reg[dips_pkg::PF_BR];
                port_new[dips_pkg::PF_BR] = 1'b1;
            end
            dips_pkg::PC_BR_INT: begin
                port_ok  = !port_reg[dips_pkg::PF_BR] && !ints_full;
                port_new = port_reg | int_bits;
                port_new[dips_pkg::PF_BR] = 1'b1;
                unit     = int_unit;
            end
            dips_pkg::PC_INT_ANY: begin
                port_ok  = !ints_full;
                port_new = port_reg | int_bits;
                unit     = int_unit;
            end
            dips_pkg::PC_SIM0: begin
                port_ok = !port_reg[dips_pkg::PF_SIM0];
                port_new[dips_pkg::PF_SIM0] = 1'b1;
                unit    = dips_pkg::UNIT_SIM0;
            end
            dips_pkg::PC_SIM1: begin
                port_ok = !port_reg[dips_pkg::PF_SIM1];
                port_new[dips_pkg::PF_SIM1] = 1'b1;
                unit    = dips_pkg::UNIT_SIM1;
            end
            dips_pkg::PC_SIM_ANY: begin
                port_ok  = !simd_full;
                port_new = port_reg | sim_bits;
                unit     = sim_unit;
            end
            dips_pkg::PC_LDST: begin
                port_ok = !port_reg[dips_pkg::PF_LDST];
                port_new[dips_pkg::PF_LDST] = 1'b1;
            end
            dips_pkg::PC_INT0: begin
                port_ok = !port_reg[dips_pkg::PF_INT0];
                port_new[dips_pkg::PF_INT0] = 1'b1;
                unit    = dips_pkg::UNIT_MUL;
            end
            dips_pkg::PC_INT1: begin
                port_ok = !port_reg[dips_pkg::PF_INT1];
                port_new[dips_pkg::PF_INT1] = 1'b1;
                unit    = dips_pkg::UNIT_DIV;
            end
            dips_pkg::PC_LDST_INT: begin
                port_ok  = !port_reg[dips_pkg::PF_LDST] && !ints_full;
                port_new = port_reg | int_bits;
                port_new[dips_pkg::PF_LDST] = 1'b1;
                unit     = int_unit;
            end
            default: begin
                port_ok = 1'b1;   // none and unused codes: no port
            end
        endcase
    end

    // Unit busy check and saturating busy-until
    always_comb begin
        uidx      = 2'(3'(unit) - 3'd1);
        unit_busy = busy_reg[uidx] > cur_reg;
        lat       = in_data.unit_latency & LAT_MASK;
        sum       = {1'b0, cur_reg} + (TIME_BITS+1)'(lat);
        busy_new  = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
    end

    // Result beat
    always_comb begin
        res_data.issued      = 1'b0;
        res_data.unit_chosen = dips_pkg::UNIT_NONE;
        if (in_data.action == dips_pkg::ACT_ISSUE && slot_ok && port_ok) begin
            res_data.unit_chosen = unit;
            res_data.issued      = (unit == dips_pkg::UNIT_NONE) || !unit_busy;
        end
    end

    // State update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
            port_reg <= '0;
            cur_reg  <= '0;
            for (int i = 0; i < 4; i++) begin
                busy_reg[i] <= '0;
            end
        end else if (step) begin
            if (in_data.action == dips_pkg::ACT_NEW_CYCLE) begin
                cur_reg  <= TIME_BITS'(in_data.cycle_now);
                slot_reg <= '0;
                port_reg <= '0;
            end else if (slot_ok && port_ok) begin
                slot_reg <= slot_new;
                port_reg <= port_new;
                if (unit != dips_pkg::UNIT_NONE && !unit_busy && lat != 8'd0) begin
                    busy_reg[uidx] <= busy_new;
                end
            end
        end
    end

endmodule

>>> hw/rtl/dips_outbuf.sv
// Two-entry result buffer (output register plus skid) for the scoreboard.
// Depends on dips_pkg. Keeps the input side open while a result is stalled.
module dips_outbuf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  dips_pkg::dips_out_t push_data,
    output logic                can_push,
    output logic                m_valid,
    input  logic                m_ready,
    output dips_pkg::dips_out_t m_data
);

    logic                out_valid_reg;
    dips_pkg::dips_out_t out_data_reg;
    logic                skid_valid_reg;
    dips_pkg::dips_out_t skid_data_reg;
    logic                pop;

    assign pop      = out_valid_reg && m_ready;
    assign can_push = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
            if (push) begin
                if (!out_valid_reg || pop) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (pop && skid_valid_reg) begin
            out_data_reg <= skid_data_reg;
        end
        if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_reg <= push_data;
            end else begin
                skid_data_reg <= push_data;
            end
        end
    end

endmodule

>>> hw/rtl/dual_issue_port_scoreboard_core.sv
// Dual-issue port scoreboard, top level. Uses dips_pkg, dips_sched, dips_outbuf.
// The result beat is registered in dips_outbuf (output register, or skid while a result is stalled).
// Throughput: one beat per cycle while s_ready is high; the claim/busy check completes in that cycle.
// A two-entry result buffer keeps s_ready high while one result is stalled.
// Reset (aresetn low, synchronous) clears slots, ports, cycle and busy times.
module dual_issue_port_scoreboard_core #(
    parameter int TIME_BITS    = dips_pkg::TIME_BITS_DEF,
    parameter int LATENCY_BITS = dips_pkg::LATENCY_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dips_pkg::dips_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dips_pkg::dips_out_t m_data
);

    logic                step;
    dips_pkg::dips_out_t res_data;

    assign step = s_valid && s_ready;

    dips_sched #(
        .TIME_BITS    (TIME_BITS),
        .LATENCY_BITS (LATENCY_BITS)
    ) u_sched (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .in_data  (s_data),
        .res_data (res_data)
    );

    dips_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (step),
        .push_data (res_data),
        .can_push  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
